FILE: rtl/mie_pkg.sv
package mie_pkg;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ITER,
    S_FIN,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic iter;
    logic fin;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic long_op;
    logic iter_last;
  } stat_t;

  // Result status codes.
  localparam logic [2:0] ST_NORMAL  = 3'd0;
  localparam logic [2:0] ST_SYSCALL = 3'd1;
  localparam logic [2:0] ST_BREAK   = 3'd2;
  localparam logic [2:0] ST_UNIMPL  = 3'd3;
  localparam logic [2:0] ST_EXT     = 3'd4;

  // Primary opcodes.
  localparam logic [5:0] OP_RFMT    = 6'h00;
  localparam logic [5:0] OP_BRCOND  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDI_U  = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0a;
  localparam logic [5:0] OP_SLTI_U  = 6'h0b;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_ORI     = 6'h0d;
  localparam logic [5:0] OP_XORI    = 6'h0e;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_COP0    = 6'h10;
  localparam logic [5:0] OP_COP2    = 6'h12;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LWL     = 6'h22;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_LWR     = 6'h26;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SWL     = 6'h2a;
  localparam logic [5:0] OP_SW      = 6'h2b;
  localparam logic [5:0] OP_SWR     = 6'h2e;
  localparam logic [5:0] OP_LWC2    = 6'h32;
  localparam logic [5:0] OP_SWC2    = 6'h3a;

  // Register-format function codes.
  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SLLV    = 6'h04;
  localparam logic [5:0] FN_SRLV    = 6'h06;
  localparam logic [5:0] FN_SRAV    = 6'h07;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0c;
  localparam logic [5:0] FN_BREAK   = 6'h0d;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MTHI    = 6'h11;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MTLO    = 6'h13;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_MULTU   = 6'h19;
  localparam logic [5:0] FN_DIV     = 6'h1a;
  localparam logic [5:0] FN_DIVU    = 6'h1b;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2a;
  localparam logic [5:0] FN_SLTU    = 6'h2b;

  // Conditional branch selectors.
  localparam logic [4:0] RI_BLTZ    = 5'h00;
  localparam logic [4:0] RI_BGEZ    = 5'h01;
  localparam logic [4:0] RI_BLTZAL  = 5'h10;
  localparam logic [4:0] RI_BGEZAL  = 5'h11;

  localparam logic [4:0] RA_IDX     = 5'd31;
  localparam logic [31:0] REGION_MASK = 32'hf000_0000;

endpackage

FILE: rtl/mie_ifs.sv
// Instruction channel.
interface mie_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr;
  logic        restart;
  logic [31:0] restart_pc;
  modport source (output valid, output instr, output restart, output restart_pc, input ready);
  modport sink (input valid, input instr, input restart, input restart_pc, output ready);
endinterface

// Result channel.
interface mie_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] fetch_pc;
  logic [2:0]  status;
  logic        wb_enable;
  logic [4:0]  wb_reg;
  logic [31:0] wb_value;
  logic [31:0] ext_base;
  logic [31:0] ext_data;
  modport source (output valid, output fetch_pc, output status, output wb_enable,
                  output wb_reg, output wb_value, output ext_base, output ext_data,
                  input ready);
  modport sink (input valid, input fetch_pc, input status, input wb_enable,
                input wb_reg, input wb_value, input ext_base, input ext_data,
                output ready);
endinterface

FILE: rtl/mie_ram.sv
module mie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/mie_ctrl.sv
module mie_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  input  mie_pkg::stat_t stat,
  output mie_pkg::cmd_t  cmd
);
  import mie_pkg::*;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    rsp_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.long_op ? S_ITER : S_DONE;
      end
      S_ITER: begin
        cmd.iter = 1'b1;
        if (stat.iter_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        rsp_valid = 1'b1;
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/mie_dp.sv
module mie_dp (
  input  logic          clk,
  input  logic          rst,
  input  mie_pkg::cmd_t  cmd,
  output mie_pkg::stat_t stat,
  input  logic [31:0]   req_instr,
  input  logic          req_restart,
  input  logic [31:0]   req_restart_pc,
  output logic [31:0]   fetch_pc,
  output logic [2:0]    status,
  output logic          wb_enable,
  output logic [4:0]    wb_reg,
  output logic [31:0]   wb_value,
  output logic [31:0]   ext_base,
  output logic [31:0]   ext_data
);
  import mie_pkg::*;

  logic [31:0] instr;
  logic        restart;
  logic [31:0] restart_pc;
  logic [31:0] pc;
  logic        pending;
  logic [31:0] target;
  logic [31:0] hi;
  logic [31:0] lo;
  logic [31:0] vld;
  logic [31:0] rd_a, rd_b;

  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sa;
  logic [31:0] imm_s, imm_z, vs, vt, cur, nxt, seq, link, btgt;
  logic        pend_now, take, wen, hi_w, lo_w, long_op, is_div, is_sgn;
  logic [4:0]  widx;
  logic [31:0] wval, tgt, hi_n, lo_n, eb, ed;
  logic [2:0]  st;
  logic        gtz;

  logic [63:0] p;
  logic [31:0] ub;
  logic        mode_div, neg_q, neg_r;
  logic [4:0]  cnt;
  logic [32:0] msum, rtmp, rdiff;
  logic [63:0] pneg;
  logic [31:0] qfix, rfix;

  // Register file: two copies for two reads, valid bits give the reset value.
  mie_ram #(.WIDTH(32), .DEPTH(32)) u_ram_a (
    .clk(clk), .we(cmd.exec && wen), .waddr(widx), .wdata(wval),
    .raddr(req_instr[25:21]), .rdata(rd_a)
  );
  mie_ram #(.WIDTH(32), .DEPTH(32)) u_ram_b (
    .clk(clk), .we(cmd.exec && wen), .waddr(widx), .wdata(wval),
    .raddr(req_instr[20:16]), .rdata(rd_b)
  );

  // Field decode.
  assign op    = instr[31:26];
  assign rs    = instr[25:21];
  assign rt    = instr[20:16];
  assign rd    = instr[15:11];
  assign sa    = instr[10:6];
  assign fn    = instr[5:0];
  assign imm_z = {16'd0, instr[15:0]};
  assign imm_s = {{16{instr[15]}}, instr[15:0]};
  assign vs    = vld[rs] ? rd_a : 32'd0;
  assign vt    = vld[rt] ? rd_b : 32'd0;

  // Program counter view for this instruction.
  assign cur      = restart ? restart_pc : pc;
  assign pend_now = restart ? 1'b0 : pending;
  assign seq      = cur + 32'd4;
  assign nxt      = pend_now ? target : seq;
  assign link     = cur + 32'd8;
  assign btgt     = seq + {imm_s[29:0], 2'b00};
  assign gtz      = !vs[31] && (vs != 32'd0);

  // Instruction decode and ALU.
  always_comb begin
    take    = 1'b0;
    tgt     = 32'd0;
    st      = ST_NORMAL;
    wen     = 1'b0;
    widx    = rd;
    wval    = 32'd0;
    hi_w    = 1'b0;
    lo_w    = 1'b0;
    hi_n    = vs;
    lo_n    = vs;
    long_op = 1'b0;
    is_div  = 1'b0;
    is_sgn  = 1'b0;
    eb      = 32'd0;
    ed      = 32'd0;
    case (op)
      OP_RFMT: begin
        wen = 1'b1;
        case (fn)
          FN_SLL:  wval = vt << sa;
          FN_SRL:  wval = vt >> sa;
          FN_SRA:  wval = 32'($signed(vt) >>> sa);
          FN_SLLV: wval = vt << vs[4:0];
          FN_SRLV: wval = vt >> vs[4:0];
          FN_SRAV: wval = 32'($signed(vt) >>> vs[4:0]);
          FN_JR: begin
            wen  = 1'b0;
            take = 1'b1;
            tgt  = vs;
          end
          FN_JALR: begin
            take = 1'b1;
            tgt  = vs;
            wval = link;
          end
          FN_SYSCALL: begin
            wen = 1'b0;
            st  = ST_SYSCALL;
          end
          FN_BREAK: begin
            wen = 1'b0;
            st  = ST_BREAK;
          end
          FN_MFHI: wval = hi;
          FN_MTHI: begin
            wen  = 1'b0;
            hi_w = 1'b1;
          end
          FN_MFLO: wval = lo;
          FN_MTLO: begin
            wen  = 1'b0;
            lo_w = 1'b1;
          end
          FN_MULT, FN_MULTU: begin
            wen     = 1'b0;
            long_op = 1'b1;
            is_sgn  = (fn == FN_MULT);
          end
          FN_DIV, FN_DIVU: begin
            wen    = 1'b0;
            is_div = 1'b1;
            is_sgn = (fn == FN_DIV);
            // A zero divisor settles at once.
            if (vt == 32'd0) begin
              hi_w = 1'b1;
              lo_w = 1'b1;
              lo_n = (is_sgn && vs[31]) ? 32'd1 : 32'hffff_ffff;
            end else begin
              long_op = 1'b1;
            end
          end
          FN_ADD, FN_ADDU: wval = vs + vt;
          FN_SUB, FN_SUBU: wval = vs - vt;
          FN_AND:  wval = vs & vt;
          FN_OR:   wval = vs | vt;
          FN_XOR:  wval = vs ^ vt;
          FN_NOR:  wval = ~(vs | vt);
          FN_SLT:  wval = {31'd0, $signed(vs) < $signed(vt)};
          FN_SLTU: wval = {31'd0, vs < vt};
          default: begin
            wen = 1'b0;
            st  = ST_UNIMPL;
          end
        endcase
      end
      OP_BRCOND: begin
        tgt  = btgt;
        widx = RA_IDX;
        wval = link;
        case (rt)
          RI_BLTZ:   take = vs[31];
          RI_BGEZ:   take = !vs[31];
          RI_BLTZAL: begin
            take = vs[31];
            wen  = 1'b1;
          end
          RI_BGEZAL: begin
            take = !vs[31];
            wen  = 1'b1;
          end
          default:   st = ST_UNIMPL;
        endcase
      end
      OP_J, OP_JAL: begin
        take = 1'b1;
        tgt  = (seq & REGION_MASK) | {4'd0, instr[25:0], 2'b00};
        widx = RA_IDX;
        wval = link;
        wen  = (op == OP_JAL);
      end
      OP_BEQ: begin
        tgt  = btgt;
        take = (vs == vt);
      end
      OP_BNE: begin
        tgt  = btgt;
        take = (vs != vt);
      end
      OP_BLEZ: begin
        tgt  = btgt;
        take = !gtz;
      end
      OP_BGTZ: begin
        tgt  = btgt;
        take = gtz;
      end
      OP_ADDI, OP_ADDI_U, OP_SLTI, OP_SLTI_U, OP_ANDI, OP_ORI, OP_XORI, OP_LUI: begin
        wen  = 1'b1;
        widx = rt;
        case (op)
          OP_ADDI, OP_ADDI_U: wval = vs + imm_s;
          OP_SLTI:   wval = {31'd0, $signed(vs) < $signed(imm_s)};
          OP_SLTI_U: wval = {31'd0, vs < imm_s};
          OP_ANDI:   wval = vs & imm_z;
          OP_ORI:    wval = vs | imm_z;
          OP_XORI:   wval = vs ^ imm_z;
          default:   wval = {instr[15:0], 16'd0};
        endcase
      end
      OP_COP0, OP_COP2, OP_LB, OP_LH, OP_LWL, OP_LW, OP_LBU, OP_LHU, OP_LWR,
      OP_SB, OP_SH, OP_SWL, OP_SW, OP_SWR, OP_LWC2, OP_SWC2: begin
        st = ST_EXT;
        eb = vs;
        ed = vt;
      end
      default: st = ST_UNIMPL;
    endcase
    // Register zero is never written.
    if (widx == 5'd0) begin
      wen = 1'b0;
    end
  end

  assign stat.long_op   = long_op;
  assign stat.iter_last = (cnt == 5'd31);

  // Iteration step: shift-add multiply or restoring divide, one bit a cycle.
  assign msum  = {1'b0, p[63:32]} + (p[0] ? {1'b0, ub} : 33'd0);
  assign rtmp  = {p[63:32], p[31]};
  assign rdiff = rtmp - {1'b0, ub};
  assign pneg  = 64'd0 - p;
  assign qfix  = neg_q ? 32'd0 - p[31:0] : p[31:0];
  assign rfix  = neg_r ? 32'd0 - p[63:32] : p[63:32];

  // Captured input item.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      instr      <= req_instr;
      restart    <= req_restart;
      restart_pc <= req_restart_pc;
    end
  end

  // Architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc      <= 32'd0;
      pending <= 1'b0;
      target  <= 32'd0;
      hi      <= 32'd0;
      lo      <= 32'd0;
      vld     <= 32'd0;
    end else if (cmd.exec) begin
      if (st == ST_SYSCALL || st == ST_BREAK) begin
        pc      <= cur;
        pending <= pend_now;
      end else begin
        pc      <= nxt;
        pending <= take;
        if (take) begin
          target <= tgt;
        end
      end
      if (hi_w) begin
        hi <= hi_n;
      end
      if (lo_w) begin
        lo <= lo_n;
      end
      if (wen) begin
        vld[widx] <= 1'b1;
      end
    end else if (cmd.fin) begin
      if (mode_div) begin
        hi <= rfix;
        lo <= qfix;
      end else begin
        hi <= neg_q ? pneg[63:32] : p[63:32];
        lo <= neg_q ? pneg[31:0] : p[31:0];
      end
    end
  end

  // Multiply/divide unit registers.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      cnt      <= 5'd0;
      mode_div <= is_div;
      neg_q    <= is_sgn && (vs[31] ^ vt[31]);
      neg_r    <= is_sgn && vs[31];
      // Divide shifts the dividend through p; multiply shifts the multiplier.
      if (is_div) begin
        ub <= (is_sgn && vt[31]) ? 32'd0 - vt : vt;
        p  <= {32'd0, (is_sgn && vs[31]) ? 32'd0 - vs : vs};
      end else begin
        p  <= {32'd0, (is_sgn && vt[31]) ? 32'd0 - vt : vt};
        ub <= (is_sgn && vs[31]) ? 32'd0 - vs : vs;
      end
    end else if (cmd.iter) begin
      cnt <= cnt + 5'd1;
      if (mode_div) begin
        if (!rdiff[32]) begin
          p <= {rdiff[31:0], p[30:0], 1'b1};
        end else begin
          p <= {rtmp[31:0], p[30:0], 1'b0};
        end
      end else begin
        p <= {msum, p[31:1]};
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      fetch_pc  <= (st == ST_SYSCALL || st == ST_BREAK) ? cur : nxt;
      status    <= st;
      wb_enable <= wen;
      wb_reg    <= wen ? widx : 5'd0;
      wb_value  <= wen ? wval : 32'd0;
      ext_base  <= eb;
      ext_data  <= ed;
    end
  end

endmodule

FILE: rtl/mips_integer_execute_unit.sv
// An accepted item passes through EXEC and then DONE, where its result is offered; so does
// a divide by zero. MULT, MULTU, DIV and DIVU pass through EXEC, ITER and FIN before DONE,
// set by the one-bit-per-cycle unit.
// A new item is taken only after the result has left, so items never overlap;
// stalls on the result hold the unit in DONE and delay the next item.
// Reset (rst, synchronous, active high) makes all registers read as zero and clears HI,
// LO, the program counter and the pending branch; the unit is ready right after.
module mips_integer_execute_unit (
  input logic clk,
  input logic rst,
  mie_req_if.sink   req,
  mie_rsp_if.source rsp
);
  import mie_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  mie_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .req_valid(req.valid), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .stat(stat), .cmd(cmd)
  );

  mie_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .req_instr(req.instr), .req_restart(req.restart), .req_restart_pc(req.restart_pc),
    .fetch_pc(rsp.fetch_pc), .status(rsp.status), .wb_enable(rsp.wb_enable),
    .wb_reg(rsp.wb_reg), .wb_value(rsp.wb_value),
    .ext_base(rsp.ext_base), .ext_data(rsp.ext_data)
  );

endmodule
